// ----- rtl/bnte_pkg.sv -----
// ----------------------------------------------------------------------------
// bnte_pkg
// Types and constants shared by the Base16/32/64 text encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bnte_pkg;

	// scheme codes held in the mode register
	localparam logic [2:0] MODE_B16U   = 3'd0;
	localparam logic [2:0] MODE_B16L   = 3'd1;
	localparam logic [2:0] MODE_B32    = 3'd2;
	localparam logic [2:0] MODE_B32HEX = 3'd3;
	localparam logic [2:0] MODE_B64    = 3'd4;
	localparam logic [2:0] MODE_B64URL = 3'd5;
	localparam logic [2:0] MODE_RESET  = MODE_B64;

	localparam logic [7:0] PAD_CHAR  = 8'h3D;
	localparam logic [3:0] MAX_CHARS = 4'd8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} byte_word_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       end_of_text;
	} char_word_t;

	// working state of the byte being encoded
	typedef struct packed {
		logic [15:0] acc;
		logic [3:0]  held;
		logic [2:0]  gp;
		logic [3:0]  cnt;
		logic        fin;
	} enc_state_t;

	// one character step
	typedef struct packed {
		logic       valid;
		logic [7:0] ch;
		logic       last;
		logic       done;
		enc_state_t nxt;
	} step_t;

endpackage

`default_nettype wire

// ----- rtl/bnte_step.sv -----
// ----------------------------------------------------------------------------
// bnte_step
// Picks the next character of the current byte (data, zero-filled tail or
// padding) and works out the state after it.
// ----------------------------------------------------------------------------
`default_nettype none

module bnte_step (
	input  wire logic [2:0]          mode,
	input  wire bnte_pkg::enc_state_t st,
	output bnte_pkg::step_t          stp
);

	function automatic logic [2:0] scheme(logic [2:0] m);
		logic [2:0] r;
		begin
			r = (m > bnte_pkg::MODE_B64URL) ? bnte_pkg::MODE_B64 : m;
			return r;
		end
	endfunction

	function automatic logic [7:0] alpha_char(logic [2:0] s, logic [5:0] idx);
		logic [7:0] i8;
		logic [7:0] r;
		begin
			i8 = {2'b00, idx};
			case (s)
				bnte_pkg::MODE_B16U:   r = (idx < 6'd10) ? 8'h30 + i8 : 8'h37 + i8;
				bnte_pkg::MODE_B16L:   r = (idx < 6'd10) ? 8'h30 + i8 : 8'h57 + i8;
				bnte_pkg::MODE_B32:    r = (idx < 6'd26) ? 8'h41 + i8 : 8'h18 + i8;
				bnte_pkg::MODE_B32HEX: r = (idx < 6'd10) ? 8'h30 + i8 : 8'h37 + i8;
				default: begin
					if (idx < 6'd26)
						r = 8'h41 + i8;
					else if (idx < 6'd52)
						r = 8'h47 + i8;
					else if (idx < 6'd62)
						r = i8 - 8'd4;
					else if (idx == 6'd62)
						r = (s == bnte_pkg::MODE_B64URL) ? 8'h2D : 8'h2B;
					else
						r = (s == bnte_pkg::MODE_B64URL) ? 8'h5F : 8'h2F;
				end
			endcase
			return r;
		end
	endfunction

	logic [2:0]  s;
	logic [2:0]  bpc;
	logic [3:0]  cpg;
	logic [5:0]  mask;
	logic [2:0]  gp_adv;
	logic        room;
	logic        has_data;
	logic        has_left;
	logic        has_pad;
	logic [3:0]  shamt;
	logic [15:0] shifted;
	logic [5:0]  data_idx;
	logic [5:0]  left_lo;
	logic [5:0]  left_idx;
	logic [3:0]  cnt_nxt;
	logic        more;

	always_comb begin
		s = scheme(mode);
		if (s == bnte_pkg::MODE_B16U || s == bnte_pkg::MODE_B16L) begin
			bpc = 3'd4;
			cpg = 4'd2;
		end else if (s == bnte_pkg::MODE_B32 || s == bnte_pkg::MODE_B32HEX) begin
			bpc = 3'd5;
			cpg = 4'd8;
		end else begin
			bpc = 3'd6;
			cpg = 4'd4;
		end
		mask = 6'((7'd1 << bpc) - 7'd1);

		// wrap also covers a position left beyond the group by a mode change
		gp_adv = (({1'b0, st.gp} + 4'd1) >= cpg) ? 3'd0 : st.gp + 3'd1;

		room     = st.cnt < bnte_pkg::MAX_CHARS;
		has_data = (st.held >= {1'b0, bpc}) && room;
		has_left = st.fin && (st.held != 4'd0) && room;
		has_pad  = st.fin && (st.gp != 3'd0) && room;

		shamt    = st.held - {1'b0, bpc};
		shifted  = st.acc >> shamt;
		data_idx = shifted[5:0] & mask;

		// tail bits sit in the low end; zero-fill below them
		left_lo  = st.acc[5:0] & 6'((7'd1 << st.held) - 7'd1);
		left_idx = 6'(left_lo << (bpc - st.held[2:0])) & mask;

		cnt_nxt = st.cnt + 4'd1;

		stp       = '0;
		stp.valid = has_data || has_left || has_pad;
		stp.nxt   = st;
		stp.nxt.cnt = cnt_nxt;
		stp.nxt.gp  = gp_adv;
		if (has_data) begin
			stp.ch = alpha_char(s, data_idx);
			stp.nxt.held = st.held - {1'b0, bpc};
		end else if (has_left) begin
			stp.ch = alpha_char(s, left_idx);
			stp.nxt.held = 4'd0;
		end else begin
			stp.ch = bnte_pkg::PAD_CHAR;
		end

		if (cnt_nxt >= bnte_pkg::MAX_CHARS)
			more = 1'b0;
		else if (st.fin)
			more = (stp.nxt.held != 4'd0) || (stp.nxt.gp != 3'd0);
		else
			more = stp.nxt.held >= {1'b0, bpc};

		stp.done = !more;
		stp.last = st.fin && !more;
		if (st.fin && !more) begin
			// message complete: start the next one clean
			stp.nxt.acc  = '0;
			stp.nxt.held = '0;
			stp.nxt.gp   = '0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/base_n_text_encoder_top.sv -----
// ----------------------------------------------------------------------------
// base_n_text_encoder_top
// Streaming RFC 4648 Base16 / Base32 / Base64 text encoder.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel : one message byte per word, final_byte set on the last one.
//   char channel : one ASCII character per word, end_of_text set on the last
//                  character of the encoded message (after any '=' padding).
//   cfg channel  : writes the 3-bit mode register (scheme); write only while
//                  no message is in flight. Always ready.
// Path: a byte is taken into the input register, moves to the state
//   register, and its first character leaves through the character register.
// Throughput: one character per cycle while char_ready stays high, set by
//   the single character step unit; a byte yields 1 to 3 characters for
//   data, and up to 8 on the final byte with tail and padding (2 per
//   byte in Base16, 4/3 on average in Base64). The next byte waits in the
//   input register while the current one drains.
// Reset: mode returns to Base64, accumulator, bit count and group position
//   clear, both channels empty.
// Stall: when the receiver holds char_ready low the character register
//   holds its word, the step unit stops, and one byte can still be taken
//   into the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module base_n_text_encoder_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_valid,
	output logic                      byte_ready,
	input  wire bnte_pkg::byte_word_t byte_word,
	output logic                      char_valid,
	input  wire logic                 char_ready,
	output bnte_pkg::char_word_t      char_word,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [2:0]           cfg_mode
);

	logic [2:0]           mode_reg_q;
	logic                 byte_valid_s1;
	bnte_pkg::byte_word_t byte_word_s1;
	bnte_pkg::enc_state_t st_q;
	bnte_pkg::enc_state_t base;
	logic                 busy_q;
	logic                 char_valid_q;
	bnte_pkg::char_word_t char_word_q;
	bnte_pkg::step_t      stp;
	logic                 emit;
	logic                 load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_reg_q <= bnte_pkg::MODE_RESET;
		end else if (cfg_valid) begin
			mode_reg_q <= cfg_mode;
		end
	end

	bnte_step u_step (
		.mode (mode_reg_q),
		.st   (st_q),
		.stp  (stp)
	);

	assign emit = busy_q && stp.valid && (!char_valid_q || char_ready);
	assign load = byte_valid_s1 && (!busy_q || (emit && stp.done));
	assign base = emit ? stp.nxt : st_q;

	assign byte_ready = !byte_valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			byte_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready)
			byte_word_s1 <= byte_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '0;
			busy_q <= 1'b0;
		end else if (load) begin
			// append the byte below the bits still held
			st_q.acc  <= {base.acc[7:0], byte_word_s1.data_byte};
			st_q.held <= base.held + 4'd8;
			st_q.gp   <= base.gp;
			st_q.cnt  <= '0;
			st_q.fin  <= byte_word_s1.final_byte;
			busy_q    <= 1'b1;
		end else if (emit) begin
			st_q <= stp.nxt;
			if (stp.done)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
		end else if (emit) begin
			char_valid_q <= 1'b1;
		end else if (char_ready) begin
			char_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_word_q.out_char    <= stp.ch;
			char_word_q.end_of_text <= stp.last;
		end
	end

	assign char_valid = char_valid_q;
	assign char_word  = char_word_q;

endmodule

`default_nettype wire

// ----- rtl/bnte_checker.sv -----
// ----------------------------------------------------------------------------
// bnte_checker
// Port-level checks for the text encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bnte_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 byte_valid,
	input wire logic                 byte_ready,
	input wire bnte_pkg::byte_word_t byte_word,
	input wire logic                 char_valid,
	input wire logic                 char_ready,
	input wire bnte_pkg::char_word_t char_word,
	input wire logic                 cfg_valid,
	input wire logic                 cfg_ready,
	input wire logic [2:0]           cfg_mode
);

	logic       pad_open_q;
	logic [7:0] c;

	assign c = char_word.out_char;

	// once padding starts, only padding follows until end of text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_open_q <= 1'b0;
		end else if (char_valid && char_ready) begin
			pad_open_q <= (c == bnte_pkg::PAD_CHAR) && !char_word.end_of_text;
		end
	end

	a_char_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_ready |=> char_valid && $stable(char_word))
		else $error("character word changed while stalled");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (c == 8'h2B || c == 8'h2D || c == 8'h2F || c == 8'h3D ||
			c == 8'h5F || (c >= 8'h30 && c <= 8'h39) ||
			(c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)))
		else $error("character outside every alphabet");

	a_pad_run: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && pad_open_q |-> c == bnte_pkg::PAD_CHAR)
		else $error("data character after padding");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("mode write refused");

	// unused by the checks, kept visible on the bind
	logic unused_ok;
	assign unused_ok = byte_valid ^ byte_ready ^ (^byte_word) ^ (^cfg_mode);

endmodule

bind base_n_text_encoder_top bnte_checker u_bnte_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_ready (byte_ready),
	.byte_word  (byte_word),
	.char_valid (char_valid),
	.char_ready (char_ready),
	.char_word  (char_word),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready),
	.cfg_mode   (cfg_mode)
);

`default_nettype wire

// ----- verif/base_n_text_encoder_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base_n_text_encoder_top_test
// Drives message bytes into the Base16/32/64 encoder under every scheme and
// checks each character word against an in-bench encoder model. Covers
// mid-message scheme changes, the spare mode codes and random flow control.
// ----------------------------------------------------------------------------

module base_n_text_encoder_top_test;

	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;
	localparam int SETTLE_CYCLES = 6;
	localparam int STUCK_LIMIT = 2000;
	localparam int RANDOM_BYTES_PER_PHASE = 60;
	localparam int PRINT_LIMIT = 40;

	typedef enum logic [1:0] {ITEM_BYTE, ITEM_MODE, ITEM_DRAIN} item_kind_t;

	typedef struct {
		item_kind_t           kind;
		logic [2:0]           mode;
		bnte_pkg::byte_word_t word;
		int unsigned          gap_pct;
		int unsigned          stall_pct;
	} pending_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 byte_valid = 1'b0;
	logic                 byte_ready;
	bnte_pkg::byte_word_t byte_word = '0;
	logic                 char_valid;
	logic                 char_ready = 1'b0;
	bnte_pkg::char_word_t char_word;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [2:0]           cfg_mode = bnte_pkg::MODE_RESET;

	pending_t             pending_items[$];
	bnte_pkg::char_word_t expected_chars[$];
	int unsigned fill_gap = 0;
	int unsigned fill_stall = 0;
	int unsigned stall_pct = 0;
	int          settle_count = 0;
	int          stuck_cycles = 0;
	int          fault_count = 0;

	// encoder model state
	logic [2:0]  model_mode = bnte_pkg::MODE_RESET;
	logic [15:0] acc = '0;
	logic [3:0]  held = '0;
	logic [2:0]  gp = '0;

	base_n_text_encoder_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_word(byte_word),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_word(char_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_mode(cfg_mode)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_fault(input string msg);
		if (fault_count < PRINT_LIMIT)
			$display("%0t ns: MISMATCH %s", $time, msg);
		fault_count++;
	endtask

	function automatic logic [7:0] alphabet_char(input logic [2:0] scheme,
		input int unsigned idx);
		case (scheme)
			bnte_pkg::MODE_B16U:   return (idx < 10) ? 8'("0" + idx) : 8'("A" + idx - 10);
			bnte_pkg::MODE_B16L:   return (idx < 10) ? 8'("0" + idx) : 8'("a" + idx - 10);
			bnte_pkg::MODE_B32:    return (idx < 26) ? 8'("A" + idx) : 8'("2" + idx - 26);
			bnte_pkg::MODE_B32HEX: return (idx < 10) ? 8'("0" + idx) : 8'("A" + idx - 10);
			default: begin
				if (idx < 26)
					return 8'("A" + idx);
				if (idx < 52)
					return 8'("a" + idx - 26);
				if (idx < 62)
					return 8'("0" + idx - 52);
				if (idx == 62)
					return (scheme == bnte_pkg::MODE_B64URL) ? "-" : "+";
				return (scheme == bnte_pkg::MODE_B64URL) ? "_" : "/";
			end
		endcase
	endfunction

	task automatic emit_char(input logic [7:0] ch, input int unsigned cpg);
		bnte_pkg::char_word_t w;
		w.out_char = ch;
		w.end_of_text = 1'b0;
		expected_chars.push_back(w);
		// a position beyond the group size wraps on the next character
		gp = (gp + 1 >= cpg) ? 3'd0 : gp + 3'd1;
	endtask

	task automatic encode_byte(input bnte_pkg::byte_word_t w);
		logic [2:0]  scheme;
		int unsigned bpc;
		int unsigned cpg;
		int unsigned mask;
		int unsigned idx;
		int          n;
		scheme = (model_mode <= bnte_pkg::MODE_B64URL) ? model_mode : bnte_pkg::MODE_B64;
		case (scheme)
			bnte_pkg::MODE_B16U, bnte_pkg::MODE_B16L: begin
				bpc = 4;
				cpg = 2;
			end
			bnte_pkg::MODE_B32, bnte_pkg::MODE_B32HEX: begin
				bpc = 5;
				cpg = 8;
			end
			default: begin
				bpc = 6;
				cpg = 4;
			end
		endcase
		mask = (1 << bpc) - 1;
		acc = {acc[7:0], w.data_byte};
		held = held + 4'd8;
		n = 0;
		while (held >= bpc && n < bnte_pkg::MAX_CHARS) begin
			idx = (acc >> (held - bpc)) & mask;
			emit_char(alphabet_char(scheme, idx), cpg);
			held = 4'(held - bpc);
			n++;
		end
		acc = 16'(acc & ((16'd1 << held) - 1));
		if (w.final_byte) begin
			// zero-fill the tail, then pad out the group
			if (held != 0 && n < bnte_pkg::MAX_CHARS) begin
				idx = (acc << (bpc - held)) & mask;
				emit_char(alphabet_char(scheme, idx), cpg);
				n++;
			end
			while (gp != 0 && n < bnte_pkg::MAX_CHARS) begin
				emit_char(bnte_pkg::PAD_CHAR, cpg);
				n++;
			end
			if (n > 0)
				expected_chars[expected_chars.size() - 1].end_of_text = 1'b1;
			acc = '0;
			held = '0;
			gp = '0;
		end
	endtask

	function automatic void add_byte(input logic [7:0] data, input logic fin);
		pending_t p;
		p.kind = ITEM_BYTE;
		p.mode = bnte_pkg::MODE_RESET;
		p.word.data_byte = data;
		p.word.final_byte = fin;
		p.gap_pct = fill_gap;
		p.stall_pct = fill_stall;
		pending_items.push_back(p);
	endfunction

	function automatic void add_ctrl(input item_kind_t kind, input logic [2:0] mode);
		pending_t p;
		p.kind = kind;
		p.mode = mode;
		p.word = '0;
		p.gap_pct = fill_gap;
		p.stall_pct = fill_stall;
		pending_items.push_back(p);
	endfunction

	function automatic logic [2:0] random_mode();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? MODE_SPARE6 : MODE_SPARE7;
		return 3'($urandom_range(bnte_pkg::MODE_B64URL));
	endfunction

	// byte and mode driver
	always @(posedge clk) begin : byte_driver
		pending_t head;
		logic     next_valid;
		logic     next_cfg;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				model_mode = cfg_mode;
			if (byte_valid && byte_ready)
				encode_byte(byte_word);
			settle_count = (expected_chars.size() == 0 && !byte_valid) ? settle_count + 1 : 0;
			next_valid = byte_valid && !byte_ready;
			next_cfg = cfg_valid && !cfg_ready;
			if (!next_valid && !next_cfg && pending_items.size() > 0) begin
				head = pending_items[0];
				stall_pct = head.stall_pct;
				case (head.kind)
					ITEM_BYTE: begin
						if ($urandom_range(99) >= head.gap_pct) begin
							next_valid = 1'b1;
							byte_word <= head.word;
							void'(pending_items.pop_front());
						end
					end
					ITEM_MODE: begin
						// write the mode only once the encoder has gone quiet
						if (settle_count >= SETTLE_CYCLES) begin
							next_cfg = 1'b1;
							cfg_mode <= head.mode;
							void'(pending_items.pop_front());
						end
					end
					default: begin
						if (expected_chars.size() == 0)
							void'(pending_items.pop_front());
					end
				endcase
			end
			byte_valid <= next_valid;
			cfg_valid <= next_cfg;
		end
	end

	// character monitor
	always @(posedge clk) begin : char_monitor
		bnte_pkg::char_word_t want;
		if (arst_n) begin
			if (char_valid && char_ready) begin
				if (expected_chars.size() == 0) begin
					report_fault($sformatf("unexpected word char=%h eot=%b",
						char_word.out_char, char_word.end_of_text));
				end else begin
					want = expected_chars.pop_front();
					if (char_word.out_char !== want.out_char)
						report_fault($sformatf("out_char got %h want %h",
							char_word.out_char, want.out_char));
					if (char_word.end_of_text !== want.end_of_text)
						report_fault($sformatf("end_of_text got %b want %b (char %h)",
							char_word.end_of_text, want.end_of_text, want.out_char));
				end
			end
			char_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((byte_valid && byte_ready) || (char_valid && char_ready) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int unsigned gaps[4];
		int unsigned stalls[4];
		int          count;
		int          len;
		gaps = '{0, 49, 0, 30};
		stalls = '{0, 0, 49, 30};

		// reset scheme first, then each scheme at its extremes
		add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b1);
		add_ctrl(ITEM_MODE, bnte_pkg::MODE_B16U);
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b1);
		add_ctrl(ITEM_MODE, bnte_pkg::MODE_B16L);
		add_byte(8'hAB, 1'b1);
		add_ctrl(ITEM_MODE, bnte_pkg::MODE_B32);
		add_byte(8'hFF, 1'b1);
		add_ctrl(ITEM_MODE, bnte_pkg::MODE_B32HEX);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b1);
		add_ctrl(ITEM_MODE, bnte_pkg::MODE_B64URL);
		add_byte(8'hFB, 1'b0);
		add_byte(8'hFF, 1'b1);
		// spare codes fall back to Base64
		add_ctrl(ITEM_MODE, MODE_SPARE6);
		add_byte(8'hFF, 1'b1);
		add_ctrl(ITEM_MODE, MODE_SPARE7);
		add_byte(8'h00, 1'b1);
		// switch Base64 -> Base32 mid-message so the final byte hits the word limit
		add_ctrl(ITEM_MODE, bnte_pkg::MODE_B64);
		add_byte(8'h5A, 1'b0);
		add_byte(8'hA5, 1'b0);
		add_ctrl(ITEM_MODE, bnte_pkg::MODE_B32);
		add_byte(8'hC3, 1'b0);
		add_byte(8'h3C, 1'b0);
		add_byte(8'h81, 1'b0);
		add_byte(8'h7E, 1'b1);
		// group position beyond the Base16 group size wraps
		add_byte(8'h12, 1'b0);
		add_byte(8'h34, 1'b0);
		add_byte(8'h56, 1'b0);
		add_byte(8'h78, 1'b0);
		add_ctrl(ITEM_MODE, bnte_pkg::MODE_B16U);
		add_byte(8'h9A, 1'b1);

		for (int p = 0; p < 4; p++) begin
			fill_gap = gaps[p];
			fill_stall = stalls[p];
			count = 0;
			while (count < RANDOM_BYTES_PER_PHASE) begin
				if ($urandom_range(1))
					add_ctrl(ITEM_MODE, random_mode());
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(8, 1);
				for (int i = 0; i < len; i++) begin
					// hold off mid-message until drained, sometimes changing scheme
					if (i > 0 && $urandom_range(19) == 0) begin
						add_ctrl(ITEM_DRAIN, bnte_pkg::MODE_RESET);
						if ($urandom_range(1))
							add_ctrl(ITEM_MODE, random_mode());
					end
					add_byte(8'($urandom_range(255)), i == len - 1);
					count++;
				end
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() > 0 || byte_valid || cfg_valid || expected_chars.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (fault_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
